/* rtl/core/cmq_pkg.sv */
package cmq_pkg;

    localparam int COORD_W = 24;
    localparam int LEN_W   = 23;
    localparam int GAP_W   = 25;
    localparam int SQ_W    = 51;
    localparam int ROOT_W  = 26;
    localparam int PROD_W  = 31;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LETHAL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INFL     = 3'd5;

    localparam logic [7:0] COST_FREE    = 8'd0;
    localparam logic [7:0] COST_MIN     = 8'd1;
    localparam logic [7:0] COST_SPAN    = 8'd180;
    localparam logic [7:0] COST_LETHAL  = 8'd254;
    localparam logic [7:0] COST_UNKNOWN = 8'd255;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_ADD   = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_GAP,
        ST_SQX,
        ST_SQY,
        ST_ROOT,
        ST_EVAL,
        ST_DIV,
        ST_DONE
    } back_state_t;

    typedef struct packed {
        logic [1:0]                req_type;
        logic signed [COORD_W-1:0] corner_ax;
        logic signed [COORD_W-1:0] corner_ay;
        logic signed [COORD_W-1:0] corner_bx;
        logic signed [COORD_W-1:0] corner_by;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } in_item_t;

    typedef struct packed {
        logic [7:0] cost;
        logic       occupied;
        logic       status;
    } out_item_t;

    typedef struct packed {
        req_t                      kind;
        logic                      outside;
        logic signed [COORD_W-1:0] lo_x;
        logic signed [COORD_W-1:0] lo_y;
        logic signed [COORD_W-1:0] hi_x;
        logic signed [COORD_W-1:0] hi_y;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
    } op_t;

endpackage

/* rtl/core/box_obstacle_costmap_query.sv */
// Obstacle box table with point cost queries. Items enter through a small queue. A query that
// lies inside the map scans every stored box, each through the steps read the box memory, axis
// gaps, square of the x gap, and square of the y gap with compare; it then takes a bit-pair
// square root of the smallest squared distance. A point in the inflation band adds a shift and
// subtract division for the cost quotient, which a lethal or free point skips. Queries outside the map or against an
// empty table finish like clear and add items. One result beat per item.
module box_obstacle_costmap_query #(
    parameter int MAX_BOXES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  cmq_pkg::in_item_t                   req_item,
    output logic                                empty,
    input  logic                                pop,
    output cmq_pkg::out_item_t                  res_item,
    input  logic                                cfg_we,
    input  logic [cmq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cmq_pkg::COORD_W-1:0]         cfg_data
);

    logic signed [cmq_pkg::COORD_W-1:0] base_x_reg, base_y_reg;
    logic [cmq_pkg::LEN_W-1:0] width_reg, height_reg, lethal_reg, infl_reg;

    cmq_pkg::op_t front_op, queue_op;
    logic         queue_empty, queue_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_x_reg <= '0;
            base_y_reg <= '0;
            width_reg  <= 23'd10240;
            height_reg <= 23'd10240;
            lethal_reg <= 23'd256;
            infl_reg   <= 23'd512;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cmq_pkg::CFG_ORIGIN_X: base_x_reg <= cfg_data;
                cmq_pkg::CFG_ORIGIN_Y: base_y_reg <= cfg_data;
                cmq_pkg::CFG_WIDTH:    width_reg  <= cfg_data[cmq_pkg::LEN_W-1:0];
                cmq_pkg::CFG_HEIGHT:   height_reg <= cfg_data[cmq_pkg::LEN_W-1:0];
                cmq_pkg::CFG_LETHAL:   lethal_reg <= cfg_data[cmq_pkg::LEN_W-1:0];
                cmq_pkg::CFG_INFL:     infl_reg   <= cfg_data[cmq_pkg::LEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    cmq_front u_front (
        .item       (req_item),
        .base_x     (base_x_reg),
        .base_y     (base_y_reg),
        .map_width  (width_reg),
        .map_height (height_reg),
        .op         (front_op)
    );

    cmq_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && !full),
        .wr_data (front_op),
        .full    (full),
        .rd_en   (queue_pop),
        .rd_data (queue_op),
        .empty   (queue_empty)
    );

    cmq_back #(
        .MAX_BOXES (MAX_BOXES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (queue_op),
        .op_valid      (!queue_empty),
        .op_pop        (queue_pop),
        .lethal_radius (lethal_reg),
        .infl_radius   (infl_reg),
        .res           (res_item),
        .empty         (empty),
        .pop           (pop)
    );

endmodule

/* rtl/core/cmq_front.sv */
module cmq_front (
    input  cmq_pkg::in_item_t                 item,
    input  logic signed [cmq_pkg::COORD_W-1:0] base_x,
    input  logic signed [cmq_pkg::COORD_W-1:0] base_y,
    input  logic [cmq_pkg::LEN_W-1:0]          map_width,
    input  logic [cmq_pkg::LEN_W-1:0]          map_height,
    output cmq_pkg::op_t                       op
);

    logic signed [cmq_pkg::COORD_W+1:0] x_lo;
    logic signed [cmq_pkg::COORD_W+1:0] x_hi;
    logic signed [cmq_pkg::COORD_W+1:0] y_lo;
    logic signed [cmq_pkg::COORD_W+1:0] y_hi;
    logic signed [cmq_pkg::COORD_W+1:0] px;
    logic signed [cmq_pkg::COORD_W+1:0] py;

    always_comb
    begin
        x_lo = {{2{base_x[cmq_pkg::COORD_W-1]}}, base_x};
        y_lo = {{2{base_y[cmq_pkg::COORD_W-1]}}, base_y};
        x_hi = x_lo + $signed({3'b000, map_width});
        y_hi = y_lo + $signed({3'b000, map_height});
        px   = {{2{item.point_x[cmq_pkg::COORD_W-1]}}, item.point_x};
        py   = {{2{item.point_y[cmq_pkg::COORD_W-1]}}, item.point_y};

        op.kind    = cmq_pkg::req_t'(item.req_type);
        op.outside = (px < x_lo) || (px > x_hi) || (py < y_lo) || (py > y_hi);
        op.px      = item.point_x;
        op.py      = item.point_y;
        if ($signed(item.corner_ax) < $signed(item.corner_bx))
        begin
            op.lo_x = item.corner_ax;
            op.hi_x = item.corner_bx;
        end
        else
        begin
            op.lo_x = item.corner_bx;
            op.hi_x = item.corner_ax;
        end
        if ($signed(item.corner_ay) < $signed(item.corner_by))
        begin
            op.lo_y = item.corner_ay;
            op.hi_y = item.corner_by;
        end
        else
        begin
            op.lo_y = item.corner_by;
            op.hi_y = item.corner_ay;
        end
    end

endmodule

/* rtl/core/cmq_fifo.sv */
module cmq_fifo (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  cmq_pkg::op_t wr_data,
    output logic         full,
    input  logic         rd_en,
    output cmq_pkg::op_t rd_data,
    output logic         empty
);

    cmq_pkg::op_t slot_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   cnt_reg;
    logic [1:0]   cnt_next;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr_en)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/core/cmq_back.sv */
module cmq_back #(
    parameter int MAX_BOXES = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cmq_pkg::op_t                op,
    input  logic                        op_valid,
    output logic                        op_pop,
    input  logic [cmq_pkg::LEN_W-1:0]   lethal_radius,
    input  logic [cmq_pkg::LEN_W-1:0]   infl_radius,
    output cmq_pkg::out_item_t          res,
    output logic                        empty,
    input  logic                        pop
);

    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW    = cmq_pkg::COORD_W;
    localparam int ENT_W = 4 * CW;

    logic [ENT_W-1:0] box_mem [MAX_BOXES];
    logic [ENT_W-1:0] rdata_reg;

    cmq_pkg::back_state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    cmq_pkg::op_t     op_reg, op_next;
    logic             mem_we;

    logic [cmq_pkg::GAP_W-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [cmq_pkg::SQ_W-1:0]  sqx_reg, sqx_next, best_reg, best_next, sq;
    logic                      have_reg, have_next;

    logic [cmq_pkg::SQ_W-1:0]  v_reg, v_next, bit_reg, bit_next;
    logic [cmq_pkg::SQ_W:0]    r_reg, r_next, trial_root;

    logic [cmq_pkg::PROD_W-1:0] prod_reg, prod_next, trial_div;
    logic [cmq_pkg::LEN_W-1:0]  span_reg, span_next;
    logic [7:0]                 q_reg, q_next, q_bit;
    logic [2:0]                 k_reg, k_next;

    logic [cmq_pkg::ROOT_W-1:0] root_dist;
    logic [cmq_pkg::LEN_W-1:0]  margin;

    logic [7:0] cost_reg, cost_next;
    logic       status_reg, status_next;
    logic [7:0] res_cost_reg, res_cost_next;
    logic       res_status_reg, res_status_next;
    logic       out_valid_reg, out_valid_next;

    logic signed [CW-1:0] e_lo_x, e_lo_y, e_hi_x, e_hi_y;

    assign empty        = !out_valid_reg;
    assign res.cost     = res_cost_reg;
    assign res.status   = res_status_reg;
    assign res.occupied = (res_cost_reg == cmq_pkg::COST_LETHAL)
                       || (res_cost_reg == cmq_pkg::COST_UNKNOWN);

    assign e_lo_x = rdata_reg[4*CW-1:3*CW];
    assign e_lo_y = rdata_reg[3*CW-1:2*CW];
    assign e_hi_x = rdata_reg[2*CW-1:CW];
    assign e_hi_y = rdata_reg[CW-1:0];

    assign root_dist = r_reg[cmq_pkg::ROOT_W-1:0];
    assign margin    = infl_radius - root_dist[cmq_pkg::LEN_W-1:0];

    function automatic logic [cmq_pkg::GAP_W-1:0] axis_gap(
        input logic signed [CW-1:0] p,
        input logic signed [CW-1:0] lo,
        input logic signed [CW-1:0] hi
    );
        logic signed [CW:0] d;
        begin
            d = '0;
            if (p < lo)
            begin
                d = $signed({lo[CW-1], lo}) - $signed({p[CW-1], p});
            end
            else if (p > hi)
            begin
                d = $signed({p[CW-1], p}) - $signed({hi[CW-1], hi});
            end
            axis_gap = d;
        end
    endfunction

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        op_next         = op_reg;
        mem_we          = 1'b0;
        op_pop          = 1'b0;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        sqx_next        = sqx_reg;
        best_next       = best_reg;
        have_next       = have_reg;
        v_next          = v_reg;
        r_next          = r_reg;
        bit_next        = bit_reg;
        prod_next       = prod_reg;
        span_next       = span_reg;
        q_next          = q_reg;
        k_next          = k_reg;
        cost_next       = cost_reg;
        status_next     = status_reg;
        res_cost_next   = res_cost_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !pop;
        sq              = sqx_reg + cmq_pkg::SQ_W'(dy_reg * dy_reg);
        trial_root      = r_reg + {1'b0, bit_reg};
        trial_div       = cmq_pkg::PROD_W'(span_reg) << k_reg;
        q_bit           = 8'd1 << k_reg;

        unique case (state_reg)
            cmq_pkg::ST_IDLE:
            begin
                if (op_valid)
                begin
                    op_pop      = 1'b1;
                    op_next     = op;
                    cost_next   = cmq_pkg::COST_FREE;
                    status_next = 1'b0;
                    state_next  = cmq_pkg::ST_DONE;
                    unique case (op.kind)
                        cmq_pkg::REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        cmq_pkg::REQ_ADD:
                        begin
                            if (count_reg < CNT_W'(MAX_BOXES))
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                status_next = 1'b1;
                            end
                        end
                        cmq_pkg::REQ_QUERY:
                        begin
                            if (op.outside)
                            begin
                                cost_next = cmq_pkg::COST_UNKNOWN;
                            end
                            else if (count_reg != '0)
                            begin
                                idx_next   = '0;
                                have_next  = 1'b0;
                                state_next = cmq_pkg::ST_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            cmq_pkg::ST_READ:
            begin
                state_next = cmq_pkg::ST_GAP;
            end
            cmq_pkg::ST_GAP:
            begin
                dx_next    = axis_gap(op_reg.px, e_lo_x, e_hi_x);
                dy_next    = axis_gap(op_reg.py, e_lo_y, e_hi_y);
                state_next = cmq_pkg::ST_SQX;
            end
            cmq_pkg::ST_SQX:
            begin
                sqx_next   = cmq_pkg::SQ_W'(dx_reg * dx_reg);
                state_next = cmq_pkg::ST_SQY;
            end
            cmq_pkg::ST_SQY:
            begin
                if (!have_reg || sq < best_reg)
                begin
                    best_next = sq;
                end
                have_next = 1'b1;
                if (CNT_W'(idx_reg) + CNT_W'(1) == count_reg)
                begin
                    v_next     = (!have_reg || sq < best_reg) ? sq : best_reg;
                    r_next     = '0;
                    bit_next   = cmq_pkg::SQ_W'(1) << (cmq_pkg::SQ_W - 1);
                    state_next = cmq_pkg::ST_ROOT;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = cmq_pkg::ST_READ;
                end
            end
            cmq_pkg::ST_ROOT:
            begin
                if ({1'b0, v_reg} >= trial_root)
                begin
                    v_next = v_reg - cmq_pkg::SQ_W'(trial_root);
                    r_next = (r_reg >> 1) + {1'b0, bit_reg};
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    state_next = cmq_pkg::ST_EVAL;
                end
            end
            cmq_pkg::ST_EVAL:
            begin
                if (root_dist <= {3'b000, lethal_radius})
                begin
                    cost_next  = cmq_pkg::COST_LETHAL;
                    state_next = cmq_pkg::ST_DONE;
                end
                else if (root_dist <= {3'b000, infl_radius})
                begin
                    prod_next  = cmq_pkg::PROD_W'(margin) * cmq_pkg::PROD_W'(cmq_pkg::COST_SPAN);
                    span_next  = infl_radius - lethal_radius;
                    q_next     = '0;
                    k_next     = 3'd7;
                    state_next = cmq_pkg::ST_DIV;
                end
                else
                begin
                    cost_next  = cmq_pkg::COST_FREE;
                    state_next = cmq_pkg::ST_DONE;
                end
            end
            cmq_pkg::ST_DIV:
            begin
                if (prod_reg >= trial_div)
                begin
                    prod_next = prod_reg - trial_div;
                    q_next    = q_reg | q_bit;
                end
                k_next = k_reg - 3'd1;
                if (k_reg == 3'd0)
                begin
                    cost_next  = (q_next == 8'd0) ? cmq_pkg::COST_MIN : q_next;
                    state_next = cmq_pkg::ST_DONE;
                end
            end
            cmq_pkg::ST_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next  = 1'b1;
                    res_cost_next   = cost_reg;
                    res_status_next = status_reg;
                    state_next      = cmq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cmq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cmq_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        op_reg         <= op_next;
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        sqx_reg        <= sqx_next;
        best_reg       <= best_next;
        have_reg       <= have_next;
        v_reg          <= v_next;
        r_reg          <= r_next;
        bit_reg        <= bit_next;
        prod_reg       <= prod_next;
        span_reg       <= span_next;
        q_reg          <= q_next;
        k_reg          <= k_next;
        cost_reg       <= cost_next;
        status_reg     <= status_next;
        res_cost_reg   <= res_cost_next;
        res_status_reg <= res_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            box_mem[count_reg[IDX_W-1:0]] <= {op.lo_x, op.lo_y, op.hi_x, op.hi_y};
        end
        rdata_reg <= box_mem[idx_reg];
    end

endmodule
